FILE: sv/osse_pkg.sv
// osse_pkg: constants, command codes and cell-chain structs for the ordered set engine.
// Used by the interfaces, the cell, the top level and the checker.
package osse_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_W    = 32;
  localparam int CMD_W    = 3;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int TREE_N   = 2 ** $clog2(CAPACITY);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_EXISTS = 3'd2,
    CMD_NEXT   = 3'd3,
    CMD_PREV   = 3'd4
  } cmd_t;

  // Update strobes broadcast to every cell.
  typedef struct packed {
    logic                    shift_up;
    logic                    shift_down;
    logic signed [KEY_W-1:0] key;
  } cell_ctrl_t;

  // Per-cell contribution to the result OR tree.
  typedef struct packed {
    logic signed [KEY_W-1:0] next_key;
    logic signed [KEY_W-1:0] prev_key;
    logic                    eq;
    logic                    has_next;
    logic                    has_prev;
  } leaf_t;

endpackage

FILE: sv/osse_in_if.sv
// osse_in_if: command channel (valid/ready plus command and key).
// Depends on osse_pkg.
interface osse_in_if import osse_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, command, key, input ready);
  modport sink   (input valid, command, key, output ready);
  modport mon    (input valid, ready, command, key);
endinterface

FILE: sv/osse_out_if.sv
// osse_out_if: result channel (valid/ready plus found, neighbour_key, full_drop).
// Depends on osse_pkg.
interface osse_out_if import osse_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic signed [KEY_W-1:0] neighbour_key;
  logic                    full_drop;

  modport source (output valid, found, neighbour_key, full_drop, input ready);
  modport sink   (input valid, found, neighbour_key, full_drop, output ready);
  modport mon    (input valid, ready, found, neighbour_key, full_drop);
endinterface

FILE: sv/osse_cell.sv
// osse_cell: one slot of the sorted key chain; compares on capture, shifts on update.
// Depends on osse_pkg.
module osse_cell import osse_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    capture,
  input  logic signed [KEY_W-1:0] probe_key,
  input  logic                    occ,
  input  logic signed [KEY_W-1:0] left_key,
  input  logic                    left_ins,
  input  logic                    left_gto,
  input  logic signed [KEY_W-1:0] right_key,
  input  logic                    right_ins,
  input  cell_ctrl_t              ctrl,
  output logic signed [KEY_W-1:0] key,
  output logic                    ins,
  output logic                    gto,
  output leaf_t                   leaf
);

  logic signed [KEY_W-1:0] key_r;
  logic                    ins_r;
  logic                    gto_r;
  logic                    eq_r;
  logic                    occ_r;
  logic                    sel_next;
  logic                    sel_prev;

  // ins: this slot is empty or holds a key >= probe (suffix of the chain)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins_r <= 1'b0;
      gto_r <= 1'b0;
      eq_r  <= 1'b0;
      occ_r <= 1'b0;
    end else if (capture) begin
      ins_r <= !occ || (key_r >= probe_key);
      gto_r <= occ && (key_r > probe_key);
      eq_r  <= occ && (key_r == probe_key);
      occ_r <= occ;
    end
  end

  // Insert: slots past the position take the left key, the position takes the new key.
  // Delete: slots from the matching key onward take the right key.
  always_ff @(posedge clk) begin
    if (ctrl.shift_up) begin
      if (left_ins) begin
        key_r <= left_key;
      end else if (ins_r) begin
        key_r <= ctrl.key;
      end
    end else if (ctrl.shift_down && ins_r) begin
      key_r <= right_key;
    end
  end

  assign sel_next = gto_r && !left_gto;
  assign sel_prev = occ_r && !ins_r && right_ins;

  assign key  = key_r;
  assign ins  = ins_r;
  assign gto  = gto_r;

  assign leaf.next_key = sel_next ? key_r : '0;
  assign leaf.prev_key = sel_prev ? key_r : '0;
  assign leaf.eq       = eq_r;
  assign leaf.has_next = sel_next;
  assign leaf.has_prev = sel_prev;

endmodule

FILE: sv/ordered_set_engine.sv
// ordered_set_engine: top level, a chain of CAPACITY key cells plus control and result register.
// Depends on osse_pkg, osse_in_if, osse_out_if and osse_cell.
//
//   channel  | dir | payload                          | handshake
//   in_ch    | in  | command[2:0], key[31:0] signed   | valid/ready
//   out_ch   | out | found, neighbour_key, full_drop  | valid/ready
//
// Per command, every cell compares its key to the probe at the
// accept edge, then the update state shifts the chain and registers the result.
// The update cycle waits while a previous result is still held on out_ch.
// in_ch.ready is high whenever no command is in its update cycle.
// Reset (synchronous, rst_n low) empties the set; no clearing pass is needed.
module ordered_set_engine import osse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  osse_in_if.sink    in_ch,
  osse_out_if.source out_ch
);

  typedef enum logic {S_IDLE, S_UPD} state_t;

  state_t                  state_r;
  cmd_t                    cmd_r;
  logic signed [KEY_W-1:0] key_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    out_valid_r;
  logic                    found_r;
  logic                    found_nxt;
  logic signed [KEY_W-1:0] nkey_r;
  logic signed [KEY_W-1:0] nkey_nxt;
  logic                    drop_r;
  logic                    drop_nxt;

  logic                    capture;
  logic                    fire;
  logic                    full;
  logic                    dup;
  cell_ctrl_t              ctrl;

  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic                    cell_ins [CAPACITY];
  logic                    cell_gto [CAPACITY];
  leaf_t                   tree     [1:2*TREE_N-1];

  assign capture = in_ch.valid && in_ch.ready;
  assign fire    = (state_r == S_UPD) && (!out_valid_r || out_ch.ready);
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign dup     = tree[1].eq;

  assign ctrl.key        = key_r;
  assign ctrl.shift_up   = fire && (cmd_r == CMD_INSERT) && !dup && !full;
  assign ctrl.shift_down = fire && (cmd_r == CMD_DELETE) && dup;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KEY_W-1:0] lkey;
      logic                    lins;
      logic                    lgto;
      logic signed [KEY_W-1:0] rkey;
      logic                    rins;

      if (i == 0) begin : g_first
        assign lkey = '0;
        assign lins = 1'b0;
        assign lgto = 1'b0;
      end else begin : g_mid_l
        assign lkey = cell_key[i-1];
        assign lins = cell_ins[i-1];
        assign lgto = cell_gto[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign rkey = '0;
        assign rins = 1'b1;
      end else begin : g_mid_r
        assign rkey = cell_key[i+1];
        assign rins = cell_ins[i+1];
      end

      osse_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .capture   (capture),
        .probe_key (in_ch.key),
        .occ       (CNT_W'(i) < count_r),
        .left_key  (lkey),
        .left_ins  (lins),
        .left_gto  (lgto),
        .right_key (rkey),
        .right_ins (rins),
        .ctrl      (ctrl),
        .key       (cell_key[i]),
        .ins       (cell_ins[i]),
        .gto       (cell_gto[i]),
        .leaf      (tree[TREE_N+i])
      );
    end

    for (i = CAPACITY; i < TREE_N; i++) begin : g_pad
      assign tree[TREE_N+i] = '0;
    end

    // At most one cell selects for next and one for prev, so OR merges cleanly.
    for (i = 1; i < TREE_N; i++) begin : g_tree
      assign tree[i] = tree[2*i] | tree[2*i+1];
    end
  endgenerate

  always_comb begin
    found_nxt = 1'b0;
    nkey_nxt  = '0;
    drop_nxt  = 1'b0;
    count_nxt = count_r;
    case (cmd_r)
      CMD_INSERT: begin
        if (!dup) begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
      end
      CMD_DELETE: begin
        if (dup) begin
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_EXISTS: found_nxt = dup;
      CMD_NEXT: begin
        found_nxt = tree[1].has_next;
        nkey_nxt  = tree[1].next_key;
      end
      CMD_PREV: begin
        found_nxt = tree[1].has_prev;
        nkey_nxt  = tree[1].prev_key;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a new result, or drop the held one once it is taken
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (capture) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (fire) begin
            state_r <= S_IDLE;
            count_r <= count_nxt;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (capture) begin
      cmd_r <= cmd_t'(in_ch.command);
      key_r <= in_ch.key;
    end
    if (fire) begin
      found_r <= found_nxt;
      nkey_r  <= nkey_nxt;
      drop_r  <= drop_nxt;
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = found_r;
  assign out_ch.neighbour_key = nkey_r;
  assign out_ch.full_drop     = drop_r;

endmodule

FILE: sv/osse_checker.sv
// osse_checker: port-level assertions for ordered_set_engine, attached by bind.
// Depends on osse_pkg.
module osse_checker import osse_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_found,
  input logic signed [KEY_W-1:0] out_neighbour_key,
  input logic                    out_full_drop
);

  // A stalled result must stay offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // One command in flight: no new transaction right after an accept
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready high during update cycle");

  // No neighbour key without a neighbour
  a_nkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_neighbour_key == '0)
    else $error("neighbour_key set while found low");

  // A dropped insert reports nothing else
  a_drop_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_drop |-> !out_found)
    else $error("full_drop together with found");

endmodule

bind ordered_set_engine osse_checker u_osse_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_found         (out_ch.found),
  .out_neighbour_key (out_ch.neighbour_key),
  .out_full_drop     (out_ch.full_drop)
);

FILE: tb/sv/osse_set_checker.sv
`timescale 1ns / 100ps
// osse_set_checker: watches both channels of ordered_set_engine, tracks the key set
// and compares every result transaction. Depends on osse_pkg, osse_in_if, osse_out_if.
module osse_set_checker import osse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  osse_in_if.mon    cmd_mon,
  osse_out_if.mon   res_mon,
  output int        errors,
  output int        pending
);

  typedef struct packed {
    logic                    found;
    logic signed [KEY_W-1:0] neighbour_key;
    logic                    full_drop;
  } set_reply_t;

  set_reply_t              expected_replies[$];
  logic signed [KEY_W-1:0] stored_keys[$];

  // Index of the first stored key >= k, or > k when strict is set.
  function automatic int key_bound(logic signed [KEY_W-1:0] k, bit strict);
    int pos;
    pos = 0;
    while (pos < stored_keys.size() &&
           (strict ? (stored_keys[pos] <= k) : (stored_keys[pos] < k)))
      pos++;
    return pos;
  endfunction

  function automatic set_reply_t apply_command(logic [CMD_W-1:0] cmd,
                                               logic signed [KEY_W-1:0] k);
    set_reply_t r;
    int         pos;
    r = '0;
    case (cmd)
      CMD_INSERT: begin
        pos = key_bound(k, 1'b0);
        if (!(pos < stored_keys.size() && stored_keys[pos] == k)) begin
          if (stored_keys.size() >= CAPACITY) r.full_drop = 1'b1;
          else stored_keys.insert(pos, k);
        end
      end
      CMD_DELETE: begin
        pos = key_bound(k, 1'b0);
        if (pos < stored_keys.size() && stored_keys[pos] == k) stored_keys.delete(pos);
      end
      CMD_EXISTS: begin
        pos = key_bound(k, 1'b0);
        r.found = (pos < stored_keys.size() && stored_keys[pos] == k);
      end
      CMD_NEXT: begin
        pos = key_bound(k, 1'b1);
        if (pos < stored_keys.size()) begin
          r.found         = 1'b1;
          r.neighbour_key = stored_keys[pos];
        end
      end
      CMD_PREV: begin
        pos = key_bound(k, 1'b0);
        if (pos > 0) begin
          r.found         = 1'b1;
          r.neighbour_key = stored_keys[pos-1];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("osse_set_checker @%0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    set_reply_t want;
    if (!rst_n) begin
      expected_replies.delete();
      stored_keys.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("result transaction with no command pending");
        end else begin
          want = expected_replies.pop_front();
          if (res_mon.found !== want.found)
            report_mismatch($sformatf("found %b, expected %b", res_mon.found, want.found));
          if (res_mon.neighbour_key !== want.neighbour_key)
            report_mismatch($sformatf("neighbour_key %0d, expected %0d",
                                      $signed(res_mon.neighbour_key),
                                      $signed(want.neighbour_key)));
          if (res_mon.full_drop !== want.full_drop)
            report_mismatch($sformatf("full_drop %b, expected %b",
                                      res_mon.full_drop, want.full_drop));
        end
      end
      if (cmd_mon.valid && cmd_mon.ready)
        expected_replies.push_back(apply_command(cmd_mon.command, cmd_mon.key));
    end
    pending = expected_replies.size();
  end

endmodule

FILE: tb/sv/ordered_set_engine_test.sv
`timescale 1ns / 100ps
// ordered_set_engine_test: clock, reset and command stimulus for ordered_set_engine,
// with bursty sending, a stalling receiver and osse_set_checker for the verdict.
module ordered_set_engine_test;
  import osse_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_C = 3'd7;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  localparam int POOL_SIZE    = 300;
  localparam int FILL_ITEMS   = 270;
  localparam int DRAIN_ITEMS  = 150;
  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_AT_A    = 1500;
  localparam int HOLD_AT_B    = 4500;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending_results;
  int   burst_left;
  logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

  osse_in_if  in_ch ();
  osse_out_if out_ch ();

  ordered_set_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  osse_set_checker chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd_mon (in_ch),
    .res_mon (out_ch),
    .errors  (fail_count),
    .pending (pending_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("ordered_set_engine_test: errors");
        $finish;
      end
    end
  end

  // Receiver: redraws its stall mode at random; two long hold-offs back up the engine.
  initial begin : receiver
    int cyc;
    int hold_left;
    int mode;
    cyc       = 0;
    hold_left = 0;
    mode      = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 96 == 0) mode = $urandom_range(0, 3);
      if (cyc == HOLD_AT_A || cyc == HOLD_AT_B) hold_left = $urandom_range(250, 350);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= (cyc % 7) < 3;
          default: out_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Offer one transaction and hold it until accepted; close the burst with a random gap, which may be empty.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic signed [KEY_W-1:0] k);
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.key     <= k;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return key_pool[$urandom_range(0, POOL_SIZE-1)];
    if (sel < 85) return key_pool[$urandom_range(0, POOL_SIZE-1)] + $urandom_range(0, 4) - 2;
    return $urandom;
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 28) return CMD_INSERT;
    if (sel < 54) return CMD_DELETE;
    if (sel < 68) return CMD_EXISTS;
    if (sel < 81) return CMD_NEXT;
    if (sel < 94) return CMD_PREV;
    if (sel < 96) return CMD_UNUSED_A;
    if (sel < 98) return CMD_UNUSED_B;
    return CMD_UNUSED_C;
  endfunction

  initial begin : stimulus
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_INSERT;
    in_ch.key     <= '0;
    rst_n         <= 1'b0;
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 0;
    key_pool[3] = -1;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    burst_left = $urandom_range(1, 24);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Empty set, extremes, duplicates, absent deletes and unused codes.
    send_cmd(CMD_EXISTS, 0);
    send_cmd(CMD_NEXT, KEY_MIN);
    send_cmd(CMD_PREV, KEY_MAX);
    send_cmd(CMD_DELETE, 5);
    send_cmd(CMD_INSERT, KEY_MIN);
    send_cmd(CMD_INSERT, KEY_MAX);
    send_cmd(CMD_INSERT, 0);
    send_cmd(CMD_INSERT, -1);
    send_cmd(CMD_INSERT, 1);
    send_cmd(CMD_INSERT, 0);
    send_cmd(CMD_EXISTS, 0);
    send_cmd(CMD_EXISTS, 2);
    send_cmd(CMD_NEXT, KEY_MAX);
    send_cmd(CMD_PREV, KEY_MIN);
    send_cmd(CMD_NEXT, KEY_MIN);
    send_cmd(CMD_PREV, KEY_MAX);
    send_cmd(CMD_NEXT, -1);
    send_cmd(CMD_PREV, 0);
    send_cmd(CMD_DELETE, 0);
    send_cmd(CMD_EXISTS, 0);
    send_cmd(CMD_NEXT, -1);
    send_cmd(CMD_UNUSED_A, KEY_MAX);
    send_cmd(CMD_UNUSED_B, KEY_MIN);
    send_cmd(CMD_UNUSED_C, -1);

    // Fill past capacity so new keys are dropped, then a duplicate while full.
    for (int i = 0; i < FILL_ITEMS; i++) send_cmd(CMD_INSERT, key_pool[i]);
    send_cmd(CMD_INSERT, key_pool[7]);
    send_cmd(CMD_NEXT, KEY_MIN);
    send_cmd(CMD_PREV, KEY_MAX);

    for (int i = 0; i < DRAIN_ITEMS; i++)
      send_cmd(CMD_DELETE, key_pool[$urandom_range(0, POOL_SIZE-1)]);

    for (int i = 0; i < RANDOM_ITEMS; i++) send_cmd(pick_cmd(), pick_key());

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ordered_set_engine_test: clean");
    end else begin
      $display("ordered_set_engine_test: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/osse_pkg.sv
sv/osse_in_if.sv
sv/osse_out_if.sv
sv/osse_cell.sv
sv/ordered_set_engine.sv
sv/osse_checker.sv
tb/sv/osse_set_checker.sv
tb/sv/ordered_set_engine_test.sv
